// ===== rtl/core/cps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// Shared widths, codes and request types for the closest-point pipeline.
// ----------------------------------------------------------------------------
package cps_pkg;

    // Coordinate width; every internal width follows from it.
    localparam int COORD_WIDTH  = 32;
    localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
    localparam int DOT_WIDTH    = PROD_WIDTH + 1;
    localparam int GAP_WIDTH    = COORD_WIDTH + 1;
    localparam int DIV_LATENCY  = DIFF_WIDTH + 1;
    localparam int SQRT_LATENCY = DIFF_WIDTH + 1;

    typedef enum logic [1:0] {
        KIND_POINT,
        KIND_VERT,
        KIND_HORZ,
        KIND_GENERAL
    } t_kind;

    typedef enum logic [1:0] {
        POS_BEGIN,
        POS_END,
        POS_MID,
        POS_DEGEN
    } t_pos;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] query_x;
        logic signed [COORD_WIDTH-1:0] query_y;
    } t_cps_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] near_x;
        logic signed [COORD_WIDTH-1:0] near_y;
        logic [GAP_WIDTH-1:0]          gap;
        t_kind                         segment_kind;
        t_pos                          position_code;
    } t_cps_out;

    // Side data that follows a request through the divider.
    typedef struct packed {
        t_cps_in pts;
        logic    neg_x;
        logic    neg_y;
        t_kind   kind;
        t_pos    pos;
    } t_side;

    // Side data that follows a request through the square root.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] near_x;
        logic signed [COORD_WIDTH-1:0] near_y;
        t_kind                         kind;
        t_pos                          pos;
    } t_tail;

endpackage

// ===== rtl/core/cps_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_div_lane
// Pipelined rounded quotient round(mag * dot / len2), one magnitude bit per
// stage, for 0 < dot < len2.
// ----------------------------------------------------------------------------
module cps_div_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [cps_pkg::DIFF_WIDTH-1:0] i_mag,
    input  logic [cps_pkg::DOT_WIDTH-1:0]  i_dot,
    input  logic [cps_pkg::DOT_WIDTH-1:0]  i_len2,
    output logic [cps_pkg::DIFF_WIDTH-1:0] o_off
);
    import cps_pkg::*;

    logic [DIFF_WIDTH-1:0] r_m   [DIFF_WIDTH];
    logic [DOT_WIDTH-1:0]  r_dot [DIFF_WIDTH];
    logic [DOT_WIDTH-1:0]  r_len [DIFF_WIDTH];
    logic [DOT_WIDTH-1:0]  r_rem [DIFF_WIDTH];
    logic [DIFF_WIDTH-1:0] r_q   [DIFF_WIDTH];
    logic [DIFF_WIDTH-1:0] r_off;

    // Each stage folds in one magnitude bit, Horner style, and keeps the
    // running quotient and remainder against len2.
    for (genvar k = 0; k < DIFF_WIDTH; k++) begin : g_step
        logic [DIFF_WIDTH-1:0] m_in;
        logic [DOT_WIDTH-1:0]  dot_in;
        logic [DOT_WIDTH-1:0]  len_in;
        logic [DOT_WIDTH-1:0]  rem_in;
        logic [DIFF_WIDTH-1:0] q_in;
        logic [DOT_WIDTH+1:0]  acc;
        logic [DOT_WIDTH+1:0]  len_x1;
        logic [DOT_WIDTH+1:0]  len_x2;
        logic [DOT_WIDTH-1:0]  n_rem;
        logic [DIFF_WIDTH-1:0] n_q;

        if (k == 0) begin : g_first
            assign m_in   = i_mag;
            assign dot_in = i_dot;
            assign len_in = i_len2;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign m_in   = r_m[k-1];
            assign dot_in = r_dot[k-1];
            assign len_in = r_len[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
        end

        always_comb begin
            acc    = {1'b0, rem_in, 1'b0}
                   + (m_in[DIFF_WIDTH-1-k] ? {2'b00, dot_in} : '0);
            len_x1 = {2'b00, len_in};
            len_x2 = {1'b0, len_in, 1'b0};
            if (acc >= len_x2) begin
                n_rem = DOT_WIDTH'(acc - len_x2);
                n_q   = {q_in[DIFF_WIDTH-2:0], 1'b0} + DIFF_WIDTH'(2);
            end else if (acc >= len_x1) begin
                n_rem = DOT_WIDTH'(acc - len_x1);
                n_q   = {q_in[DIFF_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = DOT_WIDTH'(acc);
                n_q   = {q_in[DIFF_WIDTH-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]   <= m_in;
                r_dot[k] <= dot_in;
                r_len[k] <= len_in;
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
            end
        end
    end

    // Round half up: bump when the remainder is at least half of len2.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off <= r_q[DIFF_WIDTH-1]
                   + DIFF_WIDTH'({r_rem[DIFF_WIDTH-1], 1'b0}
                                 >= {1'b0, r_len[DIFF_WIDTH-1]});
        end
    end

    assign o_off = r_off;

endmodule

// ===== rtl/core/cps_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, rounded to
// the nearest integer at the end.
// ----------------------------------------------------------------------------
module cps_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [cps_pkg::PROD_WIDTH-1:0] i_sum,
    output logic [cps_pkg::GAP_WIDTH-1:0]  o_root
);
    import cps_pkg::*;

    localparam int REM_WIDTH = DIFF_WIDTH + 2;

    logic [PROD_WIDTH-1:0] r_sum  [DIFF_WIDTH];
    logic [DIFF_WIDTH-1:0] r_root [DIFF_WIDTH];
    logic [REM_WIDTH-1:0]  r_rem  [DIFF_WIDTH];
    logic [GAP_WIDTH-1:0]  r_out;

    // Each stage brings down two radicand bits and tries one root bit.
    for (genvar k = 0; k < DIFF_WIDTH; k++) begin : g_step
        logic [PROD_WIDTH-1:0] sum_in;
        logic [DIFF_WIDTH-1:0] root_in;
        logic [REM_WIDTH-1:0]  rem_in;
        logic [REM_WIDTH+1:0]  part;
        logic [REM_WIDTH+1:0]  trial;
        logic [REM_WIDTH-1:0]  n_rem;
        logic [DIFF_WIDTH-1:0] n_root;

        if (k == 0) begin : g_first
            assign sum_in  = i_sum;
            assign root_in = '0;
            assign rem_in  = '0;
        end else begin : g_next
            assign sum_in  = r_sum[k-1];
            assign root_in = r_root[k-1];
            assign rem_in  = r_rem[k-1];
        end

        always_comb begin
            part  = {rem_in, sum_in[PROD_WIDTH-1-2*k -: 2]};
            trial = {1'b0, root_in, 2'b01};
            if (part >= trial) begin
                n_rem  = REM_WIDTH'(part - trial);
                n_root = {root_in[DIFF_WIDTH-2:0], 1'b1};
            end else begin
                n_rem  = REM_WIDTH'(part);
                n_root = {root_in[DIFF_WIDTH-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sum[k]  <= sum_in;
                r_root[k] <= n_root;
                r_rem[k]  <= n_rem;
            end
        end
    end

    // The remainder is sum - root^2; above root means nearer the next integer.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= GAP_WIDTH'(r_root[DIFF_WIDTH-1])
                   + GAP_WIDTH'(r_rem[DIFF_WIDTH-1]
                                > {2'b00, r_root[DIFF_WIDTH-1]});
        end
    end

    assign o_root = r_out;

endmodule

// ===== rtl/core/closest_point_on_segment.sv =====
`timescale 1ns / 1ps
// Pipeline: the bit-per-stage divider (34 stages) and square root (34 stages) plus eight
// arithmetic and output stages lie between request acceptance and o_out_valid.
// Throughput: one request per cycle while the skid register is empty; an output skid
// register keeps input acceptance going while the consumer stalls, until it holds a result.
// Reset: synchronous, active low; clears every valid bit, the data is not reset.
// ----------------------------------------------------------------------------
// closest_point_on_segment
// Projects a query point onto a segment, clamps it, and returns the nearest
// point, its rounded distance, the segment shape and the position code.
// ----------------------------------------------------------------------------
module closest_point_on_segment (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cps_pkg::t_cps_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cps_pkg::t_cps_out o_out_data
);
    import cps_pkg::*;

    logic en;
    logic out_free;
    logic tail_v;

    // Stage 1: differences and segment shape.
    logic                         r_s1_v;
    t_side                        r_s1_side;
    logic signed [DIFF_WIDTH-1:0] r_s1_dx, r_s1_dy, r_s1_wx, r_s1_wy;
    t_kind                        n_kind;
    t_pos                         n_pos1;

    // Stage 2: products.
    logic                         r_s2_v;
    t_side                        r_s2_side;
    logic signed [PROD_WIDTH-1:0] r_s2_pxw, r_s2_pyw, r_s2_pxx, r_s2_pyy;
    logic [DIFF_WIDTH-1:0]        r_s2_mx, r_s2_my;

    // Stage 3: dot product, squared length and clamping decision.
    logic                         r_s3_v;
    t_side                        r_s3_side;
    logic [DOT_WIDTH-1:0]         r_s3_dot, r_s3_len;
    logic [DIFF_WIDTH-1:0]        r_s3_mx, r_s3_my;
    logic signed [DOT_WIDTH-1:0]  dot_s, len_s;
    t_pos                         n_pos3;

    // Divider period.
    logic [DIV_LATENCY-1:0]       r_dv;
    t_side                        r_dd [DIV_LATENCY];
    logic [DIFF_WIDTH-1:0]        off_x, off_y;

    // Stages 4 to 7: nearest point, error, squares, sum.
    logic                         r_s4_v, r_s5_v, r_s6_v, r_s7_v;
    t_tail                        r_s4_t, r_s5_t, r_s6_t, r_s7_t;
    logic signed [COORD_WIDTH-1:0] r_s4_qx, r_s4_qy;
    t_tail                        n_tail;
    logic signed [DIFF_WIDTH-1:0] r_s5_ex, r_s5_ey;
    logic signed [PROD_WIDTH-1:0] r_s6_sxx, r_s6_syy;
    logic [PROD_WIDTH-1:0]        r_s7_sum;

    // Square root period.
    logic [SQRT_LATENCY-1:0]      r_qv;
    t_tail                        r_qd [SQRT_LATENCY];
    logic [GAP_WIDTH-1:0]         root;

    // Output register and skid register.
    logic                         r_out_v, r_skid_v;
    t_cps_out                     r_out, r_skid, tail_d;

    // The whole pipeline moves unless the skid register holds a result.
    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // Stage 1 logic: segment shape.
    always_comb begin
        if (i_in_data.start_x == i_in_data.end_x && i_in_data.start_y == i_in_data.end_y) begin
            n_kind = KIND_POINT;
            n_pos1 = POS_DEGEN;
        end else if (i_in_data.start_x == i_in_data.end_x) begin
            n_kind = KIND_VERT;
            n_pos1 = POS_MID;
        end else if (i_in_data.start_y == i_in_data.end_y) begin
            n_kind = KIND_HORZ;
            n_pos1 = POS_MID;
        end else begin
            n_kind = KIND_GENERAL;
            n_pos1 = POS_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side.pts   <= i_in_data;
            r_s1_side.neg_x <= 1'b0;
            r_s1_side.neg_y <= 1'b0;
            r_s1_side.kind  <= n_kind;
            r_s1_side.pos   <= n_pos1;
            r_s1_dx <= $signed({i_in_data.end_x[COORD_WIDTH-1], i_in_data.end_x})
                     - $signed({i_in_data.start_x[COORD_WIDTH-1], i_in_data.start_x});
            r_s1_dy <= $signed({i_in_data.end_y[COORD_WIDTH-1], i_in_data.end_y})
                     - $signed({i_in_data.start_y[COORD_WIDTH-1], i_in_data.start_y});
            r_s1_wx <= $signed({i_in_data.query_x[COORD_WIDTH-1], i_in_data.query_x})
                     - $signed({i_in_data.start_x[COORD_WIDTH-1], i_in_data.start_x});
            r_s1_wy <= $signed({i_in_data.query_y[COORD_WIDTH-1], i_in_data.query_y})
                     - $signed({i_in_data.start_y[COORD_WIDTH-1], i_in_data.start_y});
        end
    end

    // Stage 2: the four products and the magnitudes of the direction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side.pts   <= r_s1_side.pts;
            r_s2_side.kind  <= r_s1_side.kind;
            r_s2_side.pos   <= r_s1_side.pos;
            r_s2_side.neg_x <= r_s1_dx[DIFF_WIDTH-1];
            r_s2_side.neg_y <= r_s1_dy[DIFF_WIDTH-1];
            r_s2_pxw <= PROD_WIDTH'(r_s1_dx * r_s1_wx);
            r_s2_pyw <= PROD_WIDTH'(r_s1_dy * r_s1_wy);
            r_s2_pxx <= PROD_WIDTH'(r_s1_dx * r_s1_dx);
            r_s2_pyy <= PROD_WIDTH'(r_s1_dy * r_s1_dy);
            r_s2_mx  <= r_s1_dx[DIFF_WIDTH-1] ? DIFF_WIDTH'(-r_s1_dx) : DIFF_WIDTH'(r_s1_dx);
            r_s2_my  <= r_s1_dy[DIFF_WIDTH-1] ? DIFF_WIDTH'(-r_s1_dy) : DIFF_WIDTH'(r_s1_dy);
        end
    end

    // Stage 3 logic: clamp to begin or end, or leave it to the divider; a point segment stays degenerate.
    always_comb begin
        dot_s = DOT_WIDTH'(r_s2_pxw) + DOT_WIDTH'(r_s2_pyw);
        len_s = DOT_WIDTH'(r_s2_pxx) + DOT_WIDTH'(r_s2_pyy);
        if (r_s2_side.pos == POS_DEGEN) begin
            n_pos3 = POS_DEGEN;
        end else if (dot_s <= 0) begin
            n_pos3 = POS_BEGIN;
        end else if (dot_s >= len_s) begin
            n_pos3 = POS_END;
        end else begin
            n_pos3 = POS_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_side.pts   <= r_s2_side.pts;
            r_s3_side.neg_x <= r_s2_side.neg_x;
            r_s3_side.neg_y <= r_s2_side.neg_y;
            r_s3_side.kind  <= r_s2_side.kind;
            r_s3_side.pos   <= n_pos3;
            r_s3_dot        <= dot_s;
            r_s3_len        <= len_s;
            r_s3_mx         <= r_s2_mx;
            r_s3_my         <= r_s2_my;
        end
    end

    // Rounded offsets along each axis.
    cps_div_lane u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (r_s3_mx),
        .i_dot  (r_s3_dot),
        .i_len2 (r_s3_len),
        .o_off  (off_x)
    );

    cps_div_lane u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (r_s3_my),
        .i_dot  (r_s3_dot),
        .i_len2 (r_s3_len),
        .o_off  (off_y)
    );

    // Side data and valid bits alongside the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (en) begin
            r_dv <= {r_dv[DIV_LATENCY-2:0], r_s3_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0] <= r_s3_side;
            for (int k = 1; k < DIV_LATENCY; k++) begin
                r_dd[k] <= r_dd[k-1];
            end
        end
    end

    // Stage 4 logic: pick the nearest point. The true point is in range, so
    // wrapping arithmetic at coordinate width is exact.
    always_comb begin
        n_tail.kind = r_dd[DIV_LATENCY-1].kind;
        n_tail.pos  = r_dd[DIV_LATENCY-1].pos;
        unique case (r_dd[DIV_LATENCY-1].pos)
            POS_END: begin
                n_tail.near_x = r_dd[DIV_LATENCY-1].pts.end_x;
                n_tail.near_y = r_dd[DIV_LATENCY-1].pts.end_y;
            end
            POS_MID: begin
                n_tail.near_x = r_dd[DIV_LATENCY-1].neg_x
                    ? r_dd[DIV_LATENCY-1].pts.start_x - $signed(off_x[COORD_WIDTH-1:0])
                    : r_dd[DIV_LATENCY-1].pts.start_x + $signed(off_x[COORD_WIDTH-1:0]);
                n_tail.near_y = r_dd[DIV_LATENCY-1].neg_y
                    ? r_dd[DIV_LATENCY-1].pts.start_y - $signed(off_y[COORD_WIDTH-1:0])
                    : r_dd[DIV_LATENCY-1].pts.start_y + $signed(off_y[COORD_WIDTH-1:0]);
            end
            default: begin
                n_tail.near_x = r_dd[DIV_LATENCY-1].pts.start_x;
                n_tail.near_y = r_dd[DIV_LATENCY-1].pts.start_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_dv[DIV_LATENCY-1];
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
        end
    end

    // Stages 4 to 7: error vector, its squares and their sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_t   <= n_tail;
            r_s4_qx  <= r_dd[DIV_LATENCY-1].pts.query_x;
            r_s4_qy  <= r_dd[DIV_LATENCY-1].pts.query_y;
            r_s5_t   <= r_s4_t;
            r_s5_ex  <= $signed({r_s4_qx[COORD_WIDTH-1], r_s4_qx})
                      - $signed({r_s4_t.near_x[COORD_WIDTH-1], r_s4_t.near_x});
            r_s5_ey  <= $signed({r_s4_qy[COORD_WIDTH-1], r_s4_qy})
                      - $signed({r_s4_t.near_y[COORD_WIDTH-1], r_s4_t.near_y});
            r_s6_t   <= r_s5_t;
            r_s6_sxx <= PROD_WIDTH'(r_s5_ex * r_s5_ex);
            r_s6_syy <= PROD_WIDTH'(r_s5_ey * r_s5_ey);
            r_s7_t   <= r_s6_t;
            r_s7_sum <= PROD_WIDTH'(r_s6_sxx) + PROD_WIDTH'(r_s6_syy);
        end
    end

    // Rounded distance.
    cps_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_s7_sum),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
        end else if (en) begin
            r_qv <= {r_qv[SQRT_LATENCY-2:0], r_s7_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qd[0] <= r_s7_t;
            for (int k = 1; k < SQRT_LATENCY; k++) begin
                r_qd[k] <= r_qd[k-1];
            end
        end
    end

    // Result leaving the pipeline this cycle.
    assign tail_v = en && r_qv[SQRT_LATENCY-1];

    always_comb begin
        tail_d.near_x        = r_qd[SQRT_LATENCY-1].near_x;
        tail_d.near_y        = r_qd[SQRT_LATENCY-1].near_y;
        tail_d.gap           = root;
        tail_d.segment_kind  = r_qd[SQRT_LATENCY-1].kind;
        tail_d.position_code = r_qd[SQRT_LATENCY-1].pos;
    end

    // Output register with a one-entry skid behind it.
    assign out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || tail_v;
            r_skid_v <= 1'b0;
        end else if (tail_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : tail_d;
        end else if (tail_v) begin
            r_skid <= tail_d;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A result only waits in the skid register behind a waiting output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output is empty");

    // A degenerate position belongs to a point segment and to nothing else.
    a_degen_is_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.position_code == POS_DEGEN)
        |-> (o_out_data.segment_kind == KIND_POINT))
        else $error("degenerate position on a non-point segment");

    a_point_is_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.segment_kind == KIND_POINT)
        |-> (o_out_data.position_code == POS_DEGEN))
        else $error("point segment without degenerate position");

    // While the skid register is full, the pipeline must not take a request.
    a_frozen_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_out_ready) |=> r_skid_v && $stable(r_qv))
        else $error("pipeline moved while the skid register was full");
`endif

endmodule
